// File: src/double_ended_queue_core_macros.svh
// assertion macros for the double-ended queue core
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("deq check failed");

`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deq sequence check failed");

`else

`define DEQ_ASSERT(lbl, prop)

`define DEQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/deq_pkg.sv
// shared types and constants for the double-ended queue core
package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int FILL_W        = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                       command;
    logic signed [DATA_W-1:0]   value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   popped_value;
    status_t                    status;
    logic        [FILL_W-1:0]   fill_count;
  } result_t;

  typedef enum logic [1:0] {
    IDLE,
    ACCESS,
    FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic access;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

// File: src/double_ended_queue_core.sv
// double-ended queue core: a ring of DEPTH signed 32-bit slots
// item channel: item_valid/item_stall carry a command (push front, push back,
//   pop front, pop back) and a value; pops ignore the value
// result channel: result_valid/result_stall carry the popped value (zero when
//   nothing was removed), a status (ok, full on push, empty on pop) and the
//   fill level after the operation
// each transfer in gives exactly one result; a full push or an empty pop
//   changes nothing
// the sequencer steps through capture of the item, access to the single-port
//   ring memory and load of the result, which waits for a free output register;
//   a new item is taken only after the result of the last one is loaded
// a finished result waits in an output register, so the next item is taken
//   while the receiver stalls; a second result then waits until it drains
// reset empties the queue at once (front pointer and count cleared); slot
//   contents are not cleared and are only read after being written
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  deq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ctrl         (ctrl)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .item   (item),
    .result (result),
    .stat   (stat)
  );

  `DEQ_ASSERT(a_not_full_and_empty, !(stat.full && stat.empty))
  `DEQ_ASSERT_NEXT(a_one_at_a_time, item_valid && !item_stall, item_stall)
  `DEQ_ASSERT(a_empty_pop_zero, !(result_valid && result.status == ST_EMPTY) || (result.popped_value == '0 && result.fill_count == '0))
  `DEQ_ASSERT(a_full_push_level, !(result_valid && result.status == ST_FULL) || result.fill_count == FILL_W'(DEPTH))

endmodule

// File: src/deq_datapath.sv
// ring buffer storage, pointers and result register
module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  ctrl_t    ctrl,
  input  item_t    item,
  output result_t  result,
  output dp_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [DATA_W-1:0] mem [DEPTH];

  cmd_t                     cmd_r;
  logic signed [DATA_W-1:0] value_r;
  logic [AW-1:0]            front;
  logic [AW-1:0]            front_next;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [DATA_W-1:0]        rd_data;
  logic                     pop_ok;
  logic                     pop_ok_next;
  status_t                  res_status;
  status_t                  res_status_next;

  logic          empty;
  logic          full;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [SW-1:0] back_sum;
  logic [SW-1:0] last_sum;
  logic [AW-1:0] back_pos;
  logic [AW-1:0] last_pos;
  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign stat  = '{empty: empty, full: full};

  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign back_sum  = SW'(front) + SW'(count);
  assign last_sum  = back_sum - SW'(1);
  assign back_pos  = AW'((back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum);
  assign last_pos  = AW'((last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum);

  always_comb begin
    front_next      = front;
    count_next      = count;
    pop_ok_next     = pop_ok;
    res_status_next = res_status;
    we              = 1'b0;
    waddr           = front;
    re              = 1'b0;
    raddr           = front;
    if (ctrl.access) begin
      pop_ok_next     = 1'b0;
      res_status_next = ST_OK;
      unique case (cmd_r)
        CMD_PUSH_FRONT: begin
          if (full) begin
            res_status_next = ST_FULL;
          end else begin
            we         = 1'b1;
            waddr      = front_dec;
            front_next = front_dec;
            count_next = count + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            res_status_next = ST_FULL;
          end else begin
            we         = 1'b1;
            waddr      = back_pos;
            count_next = count + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            re          = 1'b1;
            raddr       = front;
            pop_ok_next = 1'b1;
            front_next  = front_inc;
            count_next  = count - CW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            re          = 1'b1;
            raddr       = last_pos;
            pop_ok_next = 1'b1;
            count_next  = count - CW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r   <= item.command;
      value_r <= item.value;
    end
    pop_ok     <= pop_ok_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= value_r;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      result.popped_value <= pop_ok ? rd_data : '0;
      result.status       <= res_status;
      result.fill_count   <= FILL_W'(count);
    end
  end

endmodule

// File: src/deq_ctrl.sv
// sequencing state machine and result valid register
module deq_ctrl
  import deq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  output logic  result_valid,
  input  logic  result_stall,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   result_valid_next;

  assign slot_free = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (item_valid) begin
          state_next = ACCESS;
        end
      end
      ACCESS: begin
        state_next = FINISH;
      end
      FINISH: begin
        if (slot_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_comb begin
    item_stall    = 1'b1;
    ctrl.capture  = 1'b0;
    ctrl.access   = 1'b0;
    ctrl.load_out = 1'b0;
    unique case (state)
      IDLE: begin
        item_stall   = 1'b0;
        ctrl.capture = item_valid;
      end
      ACCESS: begin
        ctrl.access = 1'b1;
      end
      FINISH: begin
        ctrl.load_out = slot_free;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (ctrl.load_out) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule
